FILE: rtl/positional_ordered_list_macros.svh
// Assertion macros shared by the positional ordered list RTL.
`ifndef POSITIONAL_ORDERED_LIST_MACROS_SVH
`define POSITIONAL_ORDERED_LIST_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define POL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition implies a consequence in the same cycle.
`define POL_ASSERT_IMP(lbl, ante, cons, msg) \
  `POL_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

FILE: rtl/pol_pkg.sv
// Package with sizes, operation codes and status codes of the positional ordered list.
package pol_pkg;

  localparam int LIST_DEPTH = 64;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_W     = $clog2(LIST_DEPTH);
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
  localparam int POS_W      = 7;
  localparam int CMP_W      = POS_W + 1;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_READ   = 2'd2,
    OP_SEARCH = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_RANGE = 2'd2,
    STAT_FULL  = 2'd3
  } status_e;

endpackage

FILE: rtl/pol_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module pol_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: rtl/positional_ordered_list.sv
// Top level of the positional ordered list: request decode, RAM walk and result register.
`include "positional_ordered_list_macros.svh"

// The list lives in one RAM with a single read port and a single write port, and every
// operation walks it one entry per cycle through that read port. A rejected request
// (bad position, full or empty list) answers in the cycle after it is accepted. A read
// fetches one entry. Insert and delete at position p walk the entries from p to the end
// of the list, and a search walks from the first entry until a match or the end of the
// list. One transaction is in flight at a time, and a new one is taken in the cycle in
// which the previous result is taken. No clearing pass is needed after reset.
module positional_ordered_list import pol_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   op_i,
  input  logic [POS_W-1:0]             position_i,
  input  logic signed [DATA_WIDTH-1:0] value_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   status_o,
  output logic signed [DATA_WIDTH-1:0] value_out_o,
  output logic [POS_W-1:0]             found_position_o,
  output logic [POS_W-1:0]             count_o,
  output logic                         is_empty_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_WALK = 1'b1;

  logic state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] n_q, n_d;
  logic [ADDR_W-1:0] rd_q, rd_d, src_q, src_d, ins_q, ins_d;
  logic rvalid_q, rvalid_d, first_q, first_d;
  op_e op_q, op_d;
  logic [DATA_WIDTH-1:0] val_q, val_d, got_q, got_d;
  logic out_valid_q, out_valid_d;
  status_e status_q, status_d;
  logic [DATA_WIDTH-1:0] vout_q, vout_d;
  logic [POS_W-1:0] fpos_q, fpos_d;

  logic ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;

  logic accept, match, walk_done;
  op_e in_op;
  logic [CMP_W-1:0] pos_x, cnt_x;

  pol_ram #(
    .WIDTH(DATA_WIDTH),
    .DEPTH(LIST_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(rd_q),
    .rdata_o(ram_rdata)
  );

  assign in_stall_o = (state_q != S_IDLE) || (out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;
  assign in_op      = op_e'(op_i);
  assign pos_x      = CMP_W'(position_i);
  assign cnt_x      = CMP_W'(cnt_q);

  assign match     = (state_q == S_WALK) && rvalid_q && (op_q == OP_SEARCH) &&
                     (ram_rdata == val_q);
  assign walk_done = (state_q == S_WALK) && (match || ((n_q == '0) && !rvalid_q));

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    n_d         = n_q;
    rd_d        = rd_q;
    src_d       = src_q;
    ins_d       = ins_q;
    rvalid_d    = 1'b0;
    first_d     = first_q;
    op_d        = op_q;
    val_d       = val_q;
    got_d       = got_q;
    out_valid_d = out_valid_q && out_stall_i;
    status_d    = status_q;
    vout_d      = vout_q;
    fpos_d      = fpos_q;
    ram_we      = 1'b0;
    ram_waddr   = ins_q;
    ram_wdata   = val_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d    = in_op;
          val_d   = value_i;
          ins_d   = ADDR_W'(position_i - POS_W'(1));
          first_d = 1'b1;
          vout_d  = '0;
          fpos_d  = '0;
          state_d = S_WALK;
          n_d     = CNT_W'(cnt_x - pos_x + CMP_W'(1));
          rd_d    = ADDR_W'(position_i - POS_W'(1));
          unique case (in_op) inside
            OP_INSERT: begin
              rd_d = ADDR_W'(cnt_q - CNT_W'(1));
              if ((position_i == '0) || (pos_x > cnt_x + CMP_W'(1))) begin
                status_d = STAT_RANGE;
                state_d  = S_IDLE;
              end else if (cnt_q >= CNT_W'(LIST_DEPTH)) begin
                status_d = STAT_FULL;
                state_d  = S_IDLE;
              end
            end
            OP_DELETE, OP_READ: begin
              if (in_op == OP_READ) begin
                n_d = CNT_W'(1);
              end
              if (cnt_q == '0) begin
                status_d = STAT_EMPTY;
                state_d  = S_IDLE;
              end else if ((position_i == '0) || (pos_x > cnt_x)) begin
                status_d = STAT_RANGE;
                state_d  = S_IDLE;
              end
            end
            OP_SEARCH: begin
              n_d  = cnt_q;
              rd_d = '0;
            end
            default: ;
          endcase
          if (state_d == S_IDLE) begin
            out_valid_d = 1'b1;
          end
        end
      end
      S_WALK: begin
        if (rvalid_q) begin
          first_d = 1'b0;
          if ((op_q == OP_INSERT) || ((op_q == OP_DELETE) && !first_q)) begin
            ram_we    = 1'b1;
            ram_waddr = (op_q == OP_INSERT) ? src_q + ADDR_W'(1) : src_q - ADDR_W'(1);
            ram_wdata = ram_rdata;
          end
          if (first_q && ((op_q == OP_DELETE) || (op_q == OP_READ))) begin
            got_d = ram_rdata;
          end
        end
        if (walk_done) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b1;
          status_d    = STAT_OK;
          unique case (op_q)
            OP_INSERT: begin
              ram_we    = 1'b1;
              ram_waddr = ins_q;
              ram_wdata = val_q;
              cnt_d     = cnt_q + CNT_W'(1);
            end
            OP_DELETE: begin
              cnt_d  = cnt_q - CNT_W'(1);
              vout_d = got_q;
            end
            OP_READ: begin
              vout_d = got_q;
            end
            OP_SEARCH: begin
              if (match) begin
                fpos_d = POS_W'(src_q) + POS_W'(1);
              end else begin
                status_d = STAT_EMPTY;
              end
            end
            default: ;
          endcase
        end else if (n_q != '0) begin
          rvalid_d = 1'b1;
          src_d    = rd_q;
          rd_d     = (op_q == OP_INSERT) ? rd_q - ADDR_W'(1) : rd_q + ADDR_W'(1);
          n_d      = n_q - CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      rvalid_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rvalid_q    <= rvalid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q      <= n_d;
    rd_q     <= rd_d;
    src_q    <= src_d;
    ins_q    <= ins_d;
    first_q  <= first_d;
    op_q     <= op_d;
    val_q    <= val_d;
    got_q    <= got_d;
    status_q <= status_d;
    vout_q   <= vout_d;
    fpos_q   <= fpos_d;
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign value_out_o      = vout_q;
  assign found_position_o = fpos_q;
  assign count_o          = POS_W'(cnt_q);
  assign is_empty_o       = (cnt_q == '0);

  `POL_ASSERT(a_cnt_bound, cnt_q <= CNT_W'(LIST_DEPTH), "entry count exceeds list depth")
  `POL_ASSERT_IMP(a_idle_no_read, state_q == S_IDLE, !rvalid_q, "read in flight while idle")
  `POL_ASSERT_IMP(a_out_idle, out_valid_q, state_q == S_IDLE, "result pending during a walk")
  `POL_ASSERT(a_ins_count, (walk_done && (op_q == OP_INSERT)) |=>
              (cnt_q == CNT_W'($past(cnt_q) + CNT_W'(1))), "insert did not raise the count")

endmodule
